@@ rtl/positional_list_engine_top_defines.svh @@
// Assertion macros for the positional list engine.
// Used by modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define PLE_ASSERT_NOW(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define PLE_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

@@ rtl/ple_pkg.sv @@
// Shared types and codes for the positional list engine.
// No dependencies; used by ple_cell, ple_ctrl and the top level.
`timescale 1ns / 1ps

package ple_pkg;

	// width of cell index and count fields in the chain control word
	localparam int IDX_W = 8;

	// operation codes
	localparam logic [2:0] MODE_INS_FRONT = 3'd0;
	localparam logic [2:0] MODE_INS_BACK  = 3'd1;
	localparam logic [2:0] MODE_INS_AT    = 3'd2;
	localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
	localparam logic [2:0] MODE_DEL_BACK  = 3'd4;
	localparam logic [2:0] MODE_DEL_AT    = 3'd5;
	localparam logic [2:0] MODE_DUMP      = 3'd6;

	// result status codes
	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_EMPTY   = 3'd1;
	localparam logic [2:0] STAT_POSZERO = 3'd2;
	localparam logic [2:0] STAT_RANGE   = 3'd3;
	localparam logic [2:0] STAT_FULL    = 3'd4;
	localparam logic [2:0] STAT_ENTRY   = 3'd5;

	// what every cell does this cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_op_t;

	// control word broadcast along the chain
	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] count;
	} chain_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} ple_state_t;

endpackage

@@ rtl/ple_cell.sv @@
// One storage cell of the list chain.
// Depends on ple_pkg for the chain control word.
`timescale 1ns / 1ps

module ple_cell #(
	parameter int IDX = 0
) (
	input  logic                    clk,
	input  ple_pkg::chain_ctl_t     ctl,
	input  logic signed [31:0]      ins_value,
	input  logic signed [31:0]      left_value,
	input  logic signed [31:0]      right_value,
	input  logic signed [31:0]      head_value,
	output logic signed [31:0]      value
);

	localparam int IW = ple_pkg::IDX_W;
	localparam logic [IW:0] ME = (IW + 1)'(IDX);

	logic [IW:0]        idx_x;
	logic [IW:0]        cnt_x;
	logic signed [31:0] value_q;
	logic signed [31:0] value_d;

	assign idx_x = {1'b0, ctl.idx};
	assign cnt_x = {1'b0, ctl.count};

	// pick the next word from self, neighbors, head or the new word
	always_comb begin
		value_d = value_q;
		case (ctl.op)
			ple_pkg::CELL_INS: begin
				if (ME > idx_x)
					value_d = left_value;
				else if (ME == idx_x)
					value_d = ins_value;
			end
			ple_pkg::CELL_DEL: begin
				if (ME >= idx_x)
					value_d = right_value;
			end
			ple_pkg::CELL_ROT: begin
				// rotate the occupied part left by one
				if (ME + 1'b1 == cnt_x)
					value_d = head_value;
				else if (ME + 1'b1 < cnt_x)
					value_d = right_value;
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule

@@ rtl/ple_ctrl.sv @@
// Command decode, entry count, dump sequencer and result registers.
// Depends on ple_pkg and positional_list_engine_top_defines.svh.
`timescale 1ns / 1ps
`include "positional_list_engine_top_defines.svh"

module ple_ctrl #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2:0]          mode,
	input  logic [7:0]          position,
	input  logic signed [31:0]  head_value,
	output logic                busy,
	output logic                done,
	output logic [2:0]          status,
	output logic signed [31:0]  entry_value,
	output logic                last,
	output ple_pkg::chain_ctl_t ctl
);

	localparam int IW = ple_pkg::IDX_W;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = ((CW > 8) ? CW : 8) + 1;
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	ple_pkg::ple_state_t state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      left_q, left_d;
	logic               done_q, done_d;
	logic [2:0]         status_q, status_d;
	logic signed [31:0] entry_q, entry_d;
	logic               last_q, last_d;
	logic               accept;
	logic [PW-1:0]      pos_x;
	logic [PW-1:0]      cnt_x;
	logic               full;
	logic               empty;

	assign accept = start && (state_q == ple_pkg::ST_IDLE);
	assign pos_x  = PW'(position);
	assign cnt_x  = PW'(count_q);
	assign full   = (count_q == CAP);
	assign empty  = (count_q == '0);

	// decode the word, drive the chain and set up the result
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		left_d    = left_q;
		done_d    = 1'b0;
		status_d  = ple_pkg::STAT_OK;
		entry_d   = '0;
		last_d    = 1'b1;
		ctl.op    = ple_pkg::CELL_HOLD;
		ctl.idx   = '0;
		ctl.count = IW'(count_q);
		case (state_q)
			ple_pkg::ST_IDLE: begin
				if (accept) begin
					case (mode)
						ple_pkg::MODE_INS_FRONT, ple_pkg::MODE_INS_BACK: begin
							done_d = 1'b1;
							if (full) begin
								status_d = ple_pkg::STAT_FULL;
							end else begin
								ctl.op  = ple_pkg::CELL_INS;
								ctl.idx = (mode == ple_pkg::MODE_INS_BACK) ? IW'(count_q) : '0;
								count_d = count_q + 1'b1;
							end
						end
						ple_pkg::MODE_INS_AT: begin
							done_d = 1'b1;
							if (position == 8'd0) begin
								status_d = ple_pkg::STAT_POSZERO;
							end else if (pos_x > cnt_x + 1'b1) begin
								status_d = ple_pkg::STAT_RANGE;
							end else if (full) begin
								status_d = ple_pkg::STAT_FULL;
							end else begin
								ctl.op  = ple_pkg::CELL_INS;
								ctl.idx = IW'(position - 8'd1);
								count_d = count_q + 1'b1;
							end
						end
						ple_pkg::MODE_DEL_FRONT, ple_pkg::MODE_DEL_BACK: begin
							done_d = 1'b1;
							if (empty) begin
								status_d = ple_pkg::STAT_EMPTY;
							end else begin
								ctl.op  = ple_pkg::CELL_DEL;
								ctl.idx = (mode == ple_pkg::MODE_DEL_BACK) ?
									IW'(count_q - 1'b1) : '0;
								count_d = count_q - 1'b1;
							end
						end
						ple_pkg::MODE_DEL_AT: begin
							done_d = 1'b1;
							if (position == 8'd0) begin
								status_d = ple_pkg::STAT_POSZERO;
							end else if (empty) begin
								status_d = ple_pkg::STAT_EMPTY;
							end else if (pos_x > cnt_x) begin
								status_d = ple_pkg::STAT_RANGE;
							end else begin
								ctl.op  = ple_pkg::CELL_DEL;
								ctl.idx = IW'(position - 8'd1);
								count_d = count_q - 1'b1;
							end
						end
						ple_pkg::MODE_DUMP: begin
							if (empty) begin
								done_d   = 1'b1;
								status_d = ple_pkg::STAT_EMPTY;
							end else begin
								state_d = ple_pkg::ST_DUMP;
								left_d  = count_q;
							end
						end
						default: done_d = 1'b0;  // unused mode: no result
					endcase
				end
			end
			ple_pkg::ST_DUMP: begin
				// emit the head word and rotate the list by one
				done_d   = 1'b1;
				status_d = ple_pkg::STAT_ENTRY;
				entry_d  = head_value;
				last_d   = (left_q == CW'(1));
				ctl.op   = ple_pkg::CELL_ROT;
				left_d   = left_q - 1'b1;
				if (left_q == CW'(1))
					state_d = ple_pkg::ST_IDLE;
			end
			default: state_d = ple_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ple_pkg::ST_IDLE;
			count_q <= '0;
			left_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			left_q  <= left_d;
			done_q  <= done_d;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		status_q <= status_d;
		entry_q  <= entry_d;
		last_q   <= last_d;
	end

	assign busy        = (state_q == ple_pkg::ST_DUMP);
	assign done        = done_q;
	assign status      = status_q;
	assign entry_value = entry_q;
	assign last        = last_q;

	`PLE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP, "entry count above capacity")
	`PLE_ASSERT_NEXT(a_dump_emits, state_q == ple_pkg::ST_DUMP, done && status == ple_pkg::STAT_ENTRY, "dump cycle gave no entry word")
	`PLE_ASSERT_NEXT(a_dump_end, state_q == ple_pkg::ST_DUMP && left_q == CW'(1), state_q == ple_pkg::ST_IDLE && last, "dump did not end on last entry")
	`PLE_ASSERT_NEXT(a_ins_count, accept && mode == ple_pkg::MODE_INS_FRONT && !full, count_q == CW'($past(count_q) + 1'b1), "front insert did not grow list")

endmodule

@@ rtl/positional_list_engine_top.sv @@
// Positional list engine: chain of value cells plus the controller.
// Depends on ple_pkg, ple_cell and ple_ctrl.
`timescale 1ns / 1ps

// Usage:
//   A command word (mode, value, position) is taken at a rising edge where
//   start is high and busy is low. Results come out on status, entry_value
//   and last, each valid for exactly one cycle while done is high; the
//   receiver cannot hold them off.
//   Edits (inserts and deletes) give one status word in the cycle after the
//   command; all cells shift in parallel, so a new command may follow in
//   every cycle and busy stays low.
//   A dump of N entries raises busy while the dump state runs and gives N
//   entry words on consecutive cycles, each registered from its dump cycle
//   and so later than an edit's word, the final one with last set. Each dump
//   cycle reads the head cell and rotates the occupied cells by one, so the
//   list is back in order when busy drops.
//   A dump of an empty list gives a single empty status word.
//   Unused mode seven is taken and dropped with no result.
//   Reset (arst_n low) empties the list and cancels a dump in progress;
//   cell contents are not cleared, only the entry count.

module positional_list_engine_top #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         mode,
	input  logic signed [31:0] value,
	input  logic [7:0]         position,
	output logic               busy,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [31:0] entry_value,
	output logic               last
);

	ple_pkg::chain_ctl_t ctl;
	logic signed [31:0]  cell_value [CAPACITY];

	ple_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.mode       (mode),
		.position   (position),
		.head_value (cell_value[0]),
		.busy       (busy),
		.done       (done),
		.status     (status),
		.entry_value(entry_value),
		.last       (last),
		.ctl        (ctl)
	);

	// cell chain; the first cell takes the input value on its left, the last cell loops back on itself on its right
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_w;
		logic signed [31:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = value;
		end else begin : g_mid_l
			assign left_w = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_lastc
			assign right_w = cell_value[i];
		end else begin : g_mid_r
			assign right_w = cell_value[i+1];
		end

		ple_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.ins_value  (value),
			.left_value (left_w),
			.right_value(right_w),
			.head_value (cell_value[0]),
			.value      (cell_value[i])
		);
	end

endmodule
